>>> hw/rtl/rrhs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhs_pkg
// Shared types, constants and helpers for the round-robin health selector.
// ----------------------------------------------------------------------------
package rrhs_pkg;

	localparam int NODES = 16;
	localparam int SW = $clog2(NODES);
	localparam int CW = $clog2(NODES + 1);

	typedef enum logic [1:0] {
		OP_PICK   = 2'd0,
		OP_REPORT = 2'd1,
		OP_ADD    = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_NODE = 2'd1,
		ST_NO_SLOT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_STREAK_WINDOW = 3'd0,
		REG_CHECK_INTERVAL = 3'd1,
		REG_RETRY_INTERVAL = 3'd2,
		REG_BURST_FAIL = 3'd3,
		REG_MIN_CALLS = 3'd4,
		REG_FAIL_RATIO = 3'd5
	} reg_t;

	typedef enum logic [2:0] {
		EX_IDLE,
		EX_DISPATCH,
		EX_SCAN,
		EX_REMAINDER,
		EX_FALLBACK,
		EX_REPORT,
		EX_RATIO,
		EX_DONE
	} ex_state_t;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  slot;
		logic [31:0] node_ip;
		logic [15:0] node_port;
		logic        node_tcp;
		logic        call_failed;
		logic [31:0] now_seconds;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  chosen_slot;
		logic [31:0] out_ip;
		logic [15:0] out_port;
		logic        out_tcp;
	} rsp_t;

	typedef struct packed {
		logic [31:0] streak_window;
		logic [31:0] check_interval;
		logic [31:0] retry_interval;
		logic [15:0] burst_fail_count;
		logic [15:0] min_calls_for_ratio;
		logic [8:0]  fail_ratio_q8;
	} cfg_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] a);
		return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rrhs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhs_if
// Valid/ready stream channel carrying one request (req_t) or response (rsp_t) word.
// ----------------------------------------------------------------------------
interface rrhs_req_if;
	import rrhs_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rrhs_rsp_if;
	import rrhs_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rrhs_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhs_cfg
// APB register bank holding the health thresholds and intervals.
// ----------------------------------------------------------------------------
module rrhs_cfg
	import rrhs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output cfg_t             cfg
);
	cfg_t cfg_q;
	reg_t idx;

	assign idx = reg_t'(paddr[4:2]);
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.streak_window <= 32'd10;
			cfg_q.check_interval <= 32'd60;
			cfg_q.retry_interval <= 32'd30;
			cfg_q.burst_fail_count <= 16'd5;
			cfg_q.min_calls_for_ratio <= 16'd10;
			cfg_q.fail_ratio_q8 <= 9'd128;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (idx)
				REG_STREAK_WINDOW: cfg_q.streak_window <= pwdata;
				REG_CHECK_INTERVAL: cfg_q.check_interval <= pwdata;
				REG_RETRY_INTERVAL: cfg_q.retry_interval <= pwdata;
				REG_BURST_FAIL: cfg_q.burst_fail_count <= pwdata[15:0];
				REG_MIN_CALLS: cfg_q.min_calls_for_ratio <= pwdata[15:0];
				REG_FAIL_RATIO: cfg_q.fail_ratio_q8 <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (idx)
				REG_STREAK_WINDOW: prdata = cfg_q.streak_window;
				REG_CHECK_INTERVAL: prdata = cfg_q.check_interval;
				REG_RETRY_INTERVAL: prdata = cfg_q.retry_interval;
				REG_BURST_FAIL: prdata = {16'd0, cfg_q.burst_fail_count};
				REG_MIN_CALLS: prdata = {16'd0, cfg_q.min_calls_for_ratio};
				REG_FAIL_RATIO: prdata = {23'd0, cfg_q.fail_ratio_q8};
				default: prdata = '0;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/rrhs_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhs_fifo
// Two-entry request queue between the front and the execution engine.
// ----------------------------------------------------------------------------
module rrhs_fifo
	import rrhs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	rrhs_req_if.sink   in_ch,
	rrhs_req_if.source out_ch
);
	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign out_ch.valid = (cnt_q != 2'd0);
	assign out_ch.data = mem_q[rp_q];
	assign push = in_ch.valid && in_ch.ready;
	assign pop = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_ch.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !in_ch.ready) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_empty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !out_ch.valid) else $error("valid from empty queue");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/rrhs_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrhs_exec
// Execution engine: slot table, round-robin scan, health bookkeeping.
// ----------------------------------------------------------------------------
module rrhs_exec
	import rrhs_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	rrhs_req_if.sink   req,
	rrhs_rsp_if.source rsp
);
	logic [NODES-1:0] valid_q;
	logic [NODES-1:0] up_q;
	logic [48:0] addr_q [NODES];
	logic [31:0] okc_q [NODES];
	logic [31:0] failc_q [NODES];
	logic [31:0] streak_q [NODES];
	logic [31:0] sdl_q [NODES];
	logic [31:0] cdl_q [NODES];
	logic [31:0] retry_q [NODES];
	logic [SW-1:0] next_q;
	logic [15:0] lfsr_q;

	ex_state_t st_q, st_d;
	req_t r_q;
	logic [SW-1:0] ptr_q;
	logic [CW-1:0] step_q;
	logic [CW-1:0] cnt_q;
	logic [15:0] rank_q;
	logic [32:0] total_q;
	rsp_t rsp_q;
	logic rsp_v_q;

	logic [SW-1:0] si;
	logic [SW-1:0] p;
	logic [31:0] now;
	logic [15:0] lfsr_nx;
	logic [31:0] fc_i, sc_i;
	logic [41:0] lhs, rhs;
	logic [5:0] rem_sh;
	logic burst_hit, ratio_chk;

	assign si = r_q.slot[SW-1:0];
	assign p = ptr_q;
	assign now = r_q.now_seconds;
	assign lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);
	assign fc_i = sat_inc(failc_q[si]);
	assign sc_i = sat_inc(streak_q[si]);
	assign lhs = {2'b0, failc_q[si], 8'd0};
	assign rhs = 42'(total_q) * 42'(cfg.fail_ratio_q8);
	assign rem_sh = {rank_q[4:0], lfsr_q[~step_q[3:0]]};
	assign burst_hit = r_q.call_failed && sc_i >= {16'd0, cfg.burst_fail_count}
		&& now >= ((streak_q[si] == '0) ? sat_add(now, cfg.streak_window) : sdl_q[si]);
	assign ratio_chk = up_q[si] && r_q.call_failed && !burst_hit && now >= cdl_q[si];

	assign req.ready = (st_q == EX_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.data = rsp_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			EX_IDLE: if (req.valid && req.ready) st_d = EX_DISPATCH;
			EX_DISPATCH: begin
				unique case (op_t'(r_q.opcode))
					OP_PICK: st_d = EX_SCAN;
					OP_REPORT: st_d = valid_q[si] ? EX_REPORT : EX_DONE;
					default: st_d = EX_DONE;
				endcase
			end
			EX_SCAN: begin
				if (valid_q[p] && (up_q[p] || now >= retry_q[p])) st_d = EX_DONE;
				else if (step_q == CW'(NODES - 1)) begin
					if (cnt_q == '0 && !(valid_q[p] && !up_q[p])) st_d = EX_DONE;
					else st_d = EX_REMAINDER;
				end
			end
			EX_REMAINDER: if (step_q == CW'(15)) st_d = EX_FALLBACK;
			EX_FALLBACK: if (valid_q[p] && rank_q == '0) st_d = EX_DONE;
			EX_REPORT: st_d = ratio_chk ? EX_RATIO : EX_DONE;
			EX_RATIO: st_d = EX_DONE;
			EX_DONE: st_d = EX_IDLE;
			default: st_d = EX_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= EX_IDLE;
			valid_q <= '0;
			next_q <= '0;
			lfsr_q <= LFSR_SEED;
			rsp_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (rsp.valid && rsp.ready) rsp_v_q <= 1'b0;
			unique case (st_q)
				EX_IDLE: if (req.valid && req.ready) begin
					r_q <= req.data;
					rsp_q <= '0;
				end
				EX_DISPATCH: begin
					ptr_q <= next_q;
					step_q <= '0;
					cnt_q <= '0;
					unique case (op_t'(r_q.opcode))
						OP_PICK: ;
						OP_REPORT: if (!valid_q[si]) rsp_q.status <= ST_NO_SLOT;
						OP_ADD: begin
							addr_q[si] <= {r_q.node_ip, r_q.node_port, r_q.node_tcp};
							if (!valid_q[si]) begin
								valid_q[si] <= 1'b1;
								up_q[si] <= 1'b1;
								okc_q[si] <= '0;
								failc_q[si] <= '0;
								streak_q[si] <= '0;
								sdl_q[si] <= '0;
								cdl_q[si] <= '0;
								retry_q[si] <= '0;
							end
						end
						default: begin
							if (!valid_q[si]) rsp_q.status <= ST_NO_SLOT;
							else valid_q[si] <= 1'b0;
						end
					endcase
				end
				EX_SCAN: begin
					if (valid_q[p] && (up_q[p] || now >= retry_q[p])) begin
						if (!up_q[p]) retry_q[p] <= sat_add(now, cfg.retry_interval);
						next_q <= p + SW'(1);
						rsp_q <= {ST_OK, 4'(p), addr_q[p][48:17], addr_q[p][16:1],
							addr_q[p][0]};
					end else if (step_q == CW'(NODES - 1)) begin
						if (cnt_q == '0 && !valid_q[p]) rsp_q.status <= ST_NO_NODE;
						else begin
							lfsr_q <= lfsr_nx;
							cnt_q <= valid_q[p] ? cnt_q + CW'(1) : cnt_q;
							rank_q <= '0;
							step_q <= '0;
							ptr_q <= next_q;
						end
					end else begin
						if (valid_q[p]) cnt_q <= cnt_q + CW'(1);
						ptr_q <= p + SW'(1);
						step_q <= step_q + CW'(1);
					end
				end
				EX_REMAINDER: begin
					if (rem_sh >= {1'b0, cnt_q}) rank_q <= 16'(rem_sh - {1'b0, cnt_q});
					else rank_q <= 16'(rem_sh);
					step_q <= step_q + CW'(1);
				end
				EX_FALLBACK: begin
					if (valid_q[p]) begin
						if (rank_q == '0)
							rsp_q <= {ST_OK, 4'(p), addr_q[p][48:17], addr_q[p][16:1],
								addr_q[p][0]};
						rank_q <= rank_q - 16'd1;
					end
					ptr_q <= p + SW'(1);
				end
				EX_REPORT: begin
					if (!up_q[si]) begin
						if (!r_q.call_failed) begin
							up_q[si] <= 1'b1;
							okc_q[si] <= 32'd1;
							failc_q[si] <= '0;
							streak_q[si] <= '0;
							sdl_q[si] <= sat_add(now, cfg.streak_window);
							cdl_q[si] <= sat_add(now, cfg.check_interval);
						end else failc_q[si] <= fc_i;
					end else if (burst_hit) begin
						failc_q[si] <= fc_i;
						streak_q[si] <= sc_i;
						if (streak_q[si] == '0) sdl_q[si] <= sat_add(now, cfg.streak_window);
						up_q[si] <= 1'b0;
						retry_q[si] <= sat_add(now, cfg.retry_interval);
					end else begin
						if (r_q.call_failed) begin
							failc_q[si] <= fc_i;
							streak_q[si] <= sc_i;
							if (streak_q[si] == '0)
								sdl_q[si] <= sat_add(now, cfg.streak_window);
							total_q <= {1'b0, okc_q[si]} + {1'b0, fc_i};
						end else begin
							streak_q[si] <= '0;
							if (now >= cdl_q[si]) begin
								okc_q[si] <= '0;
								failc_q[si] <= '0;
							end else okc_q[si] <= sat_inc(okc_q[si]);
						end
						if (now >= cdl_q[si]) cdl_q[si] <= sat_add(now, cfg.check_interval);
					end
				end
				EX_RATIO: begin
					if (total_q >= {17'd0, cfg.min_calls_for_ratio} && lhs >= rhs) begin
						up_q[si] <= 1'b0;
						retry_q[si] <= sat_add(now, cfg.retry_interval);
					end else begin
						okc_q[si] <= '0;
						failc_q[si] <= '0;
					end
				end
				EX_DONE: rsp_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != EX_IDLE |-> !req.ready) else $error("accepted while busy");
	a_done_shows: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == EX_DONE |=> rsp.valid) else $error("result not raised");
	a_pick_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_NO_NODE |-> valid_q == '0 ||
		r_q.opcode == OP_PICK) else $error("bad no-node status");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/round_robin_health_selector_top.sv
`default_nettype none
// The engine holds one word at a time; it takes the next word only once the result
// is taken. Add, remove and a report of an empty slot finish after dispatch; a report
// adds a report step and may add a ratio check; a pick scans the slot table and, if no
// node is usable, computes an LFSR remainder and walks a fallback to the chosen node.
// Reset clears the valid bits, next index and FSM state, seeds the LFSR (0xACE1) and loads config defaults.
// ----------------------------------------------------------------------------
// round_robin_health_selector_top
// Round-robin backend selector with per-node circuit breaker.
// ----------------------------------------------------------------------------
module round_robin_health_selector_top
	import rrhs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	rrhs_req_if.sink         req,
	rrhs_rsp_if.source       rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	cfg_t cfg;
	rrhs_req_if q_ch ();

	rrhs_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	rrhs_fifo u_fifo (.clk, .arst_n, .in_ch(req), .out_ch(q_ch.source));

	rrhs_exec u_exec (.clk, .arst_n, .cfg, .req(q_ch.sink), .rsp);
endmodule
`default_nettype wire
